// File: rtl/trms_pkg.sv
// ----------------------------------------------------------------------------
// trms_pkg
// shared constants, types and the arctangent table for the motion step unit
// ----------------------------------------------------------------------------
package trms_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ANGLE_TABLE_LEN   = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ANGLE_TABLE_LEN) ?
                                     CORDIC_ITERATIONS : ANGLE_TABLE_LEN;
  localparam int SCALE_STAGES      = 4;
  localparam int LATENCY           = CORDIC_STEPS + 2 + SCALE_STAGES;

  localparam int DATA_W = 136;
  localparam int CW     = 34;

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t CORDIC_GAIN  = 34'sd652032874;
  localparam cw_t QUARTER_TURN = 34'sd1073741824;
  localparam cw_t HALF_TURN    = 34'sd2147483648;

  localparam logic [15:0] TIME_STEP_RESET = 16'd6554;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] speed;
    logic        [15:0] heading;
    logic signed [23:0] turn_rate;
    logic signed [40:0] rate_prod;
  } side_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic cw_t atan_entry(input logic [4:0] idx);
    cw_t val;
    case (idx)
      5'd0:    val = 34'sh020000000;
      5'd1:    val = 34'sh012E4051E;
      5'd2:    val = 34'sh009FB385B;
      5'd3:    val = 34'sh0051111D4;
      5'd4:    val = 34'sh0028B0D43;
      5'd5:    val = 34'sh00145D7E1;
      5'd6:    val = 34'sh000A2F61E;
      5'd7:    val = 34'sh000517C55;
      5'd8:    val = 34'sh00028BE53;
      5'd9:    val = 34'sh000145F2F;
      5'd10:   val = 34'sh0000A2F98;
      5'd11:   val = 34'sh0000517CC;
      5'd12:   val = 34'sh000028BE6;
      5'd13:   val = 34'sh0000145F3;
      5'd14:   val = 34'sh00000A2FA;
      5'd15:   val = 34'sh00000517D;
      5'd16:   val = 34'sh0000028BE;
      5'd17:   val = 34'sh00000145F;
      5'd18:   val = 34'sh000000A30;
      5'd19:   val = 34'sh000000518;
      5'd20:   val = 34'sh00000028C;
      5'd21:   val = 34'sh000000146;
      5'd22:   val = 34'sh0000000A3;
      5'd23:   val = 34'sh000000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/trms_cordic.sv
// ----------------------------------------------------------------------------
// trms_cordic
// pipelined rotation cordic: heading angle to cos and sin in q1.30
// ----------------------------------------------------------------------------
module trms_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         heading,
  input  trms_pkg::side_t     in_side,
  output logic                out_valid,
  output logic signed [31:0]  cos_val,
  output logic signed [31:0]  sin_val,
  output trms_pkg::side_t     out_side
);
  import trms_pkg::*;

  cw_t   x_r     [0:CORDIC_STEPS];
  cw_t   y_r     [0:CORDIC_STEPS];
  cw_t   z_r     [0:CORDIC_STEPS];
  logic  flip_r  [0:CORDIC_STEPS];
  logic  valid_r [0:CORDIC_STEPS];
  side_t side_r  [0:CORDIC_STEPS];

  logic               out_valid_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;
  side_t              out_side_r;

  logic signed [31:0] ang_w;
  cw_t                ang_ext;
  cw_t                z0_nxt;
  logic               flip_nxt;

  assign ang_w   = {heading, 16'h0000};
  assign ang_ext = {{(CW-32){ang_w[31]}}, ang_w};

  // fold into the right half plane
  always_comb begin
    z0_nxt   = ang_ext;
    flip_nxt = 1'b0;
    if (ang_ext > QUARTER_TURN) begin
      z0_nxt   = ang_ext - HALF_TURN;
      flip_nxt = 1'b1;
    end else if (ang_ext < -QUARTER_TURN) begin
      z0_nxt   = ang_ext + HALF_TURN;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= z0_nxt;
      flip_r[0] <= flip_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_iter
    cw_t x_nxt;
    cw_t y_nxt;
    cw_t z_nxt;

    always_comb begin
      if (!z_r[g][CW-1]) begin
        x_nxt = x_r[g] - (y_r[g] >>> g);
        y_nxt = y_r[g] + (x_r[g] >>> g);
        z_nxt = z_r[g] - atan_entry(5'(g));
      end else begin
        x_nxt = x_r[g] + (y_r[g] >>> g);
        y_nxt = y_r[g] - (x_r[g] >>> g);
        z_nxt = z_r[g] + atan_entry(5'(g));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g+1] <= 1'b0;
      end else if (en) begin
        valid_r[g+1] <= valid_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g+1]    <= x_nxt;
        y_r[g+1]    <= y_nxt;
        z_r[g+1]    <= z_nxt;
        flip_r[g+1] <= flip_r[g];
        side_r[g+1] <= side_r[g];
      end
    end
  end

  cw_t                x_fin;
  cw_t                y_fin;
  logic signed [31:0] cos_nxt;
  logic signed [31:0] sin_nxt;

  assign x_fin   = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign y_fin   = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  assign cos_nxt = x_fin[31:0];
  assign sin_nxt = y_fin[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r      <= cos_nxt;
      sin_r      <= sin_nxt;
      out_side_r <= side_r[CORDIC_STEPS];
    end
  end

  assign out_valid = out_valid_r;
  assign cos_val   = cos_r;
  assign sin_val   = sin_r;
  assign out_side  = out_side_r;

endmodule

// File: rtl/trms_scale.sv
// ----------------------------------------------------------------------------
// trms_scale
// one axis: pos + round(round(speed * trig) * dt), saturated to 32 bits
// ----------------------------------------------------------------------------
module trms_scale (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] trig,
  input  logic signed [31:0] speed,
  input  logic signed [31:0] pos,
  input  logic [15:0]        time_step,
  output logic signed [31:0] result,
  output logic               sat
);
  import trms_pkg::*;

  logic signed [63:0] prod_r;
  logic signed [31:0] pos1_r;
  logic signed [33:0] t_r;
  logic signed [31:0] pos2_r;
  logic signed [50:0] p2_r;
  logic signed [31:0] pos3_r;
  logic signed [31:0] result_r;
  logic               sat_r;

  logic signed [63:0] rnd1;
  logic signed [33:0] t_nxt;
  logic signed [16:0] dt_s;
  logic signed [50:0] p2_nxt;
  logic signed [50:0] rnd2;
  logic signed [34:0] d_val;
  logic signed [35:0] sum;
  logic signed [31:0] result_nxt;
  logic               sat_nxt;

  assign rnd1   = prod_r + 64'sd536870912;
  assign t_nxt  = rnd1[63:30];
  assign dt_s   = $signed({1'b0, time_step});
  assign p2_nxt = t_r * dt_s;
  assign rnd2   = p2_r + 51'sd32768;
  assign d_val  = rnd2[50:16];
  assign sum    = 36'(pos3_r) + 36'(d_val);

  always_comb begin
    result_nxt = sum[31:0];
    sat_nxt    = 1'b0;
    if (sum > 36'sd2147483647) begin
      result_nxt = 32'sh7FFFFFFF;
      sat_nxt    = 1'b1;
    end else if (sum < -36'sd2147483648) begin
      result_nxt = 32'sh80000000;
      sat_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= speed * trig;
      pos1_r   <= pos;
      t_r      <= t_nxt;
      pos2_r   <= pos1_r;
      p2_r     <= p2_nxt;
      pos3_r   <= pos2_r;
      result_r <= result_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign result = result_r;
  assign sat    = sat_r;

endmodule

// File: rtl/turn_rate_motion_step_unit.sv
// ----------------------------------------------------------------------------
// turn_rate_motion_step_unit
// one euler step of the constant turn rate and velocity motion model
// ----------------------------------------------------------------------------
// in channel: one motion state per transaction (x, y, speed, heading,
// turn rate). out channel: the propagated state, with tuser set when a
// position was clamped to the 32 bit range. cfg_wr_en loads the step length
// time_step (units of 2^-16 s), which is taken to be steady while items are
// in flight; reset loads 6554.
// the pipeline has one fold stage, one stage per cordic rotation, one sign
// stage, then four stages of multiply, round and saturate per axis.
// throughput is one transaction per cycle while out_tready does not stall
// the pipeline; the cordic rotation stages set the depth.
// when out_tready is low with a result waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated. reset empties the pipeline.
// ----------------------------------------------------------------------------
module turn_rate_motion_step_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [15:0]                 cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pos_x, pos_y, speed, heading, turn_rate
  input  logic [trms_pkg::DATA_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // next_x, next_y, next_speed, next_heading, next_turn_rate
  output logic [trms_pkg::DATA_W-1:0] out_tdata,
  // saturated
  output logic [0:0]                  out_tuser
);
  import trms_pkg::*;

  typedef struct packed {
    logic signed [31:0] speed;
    logic        [15:0] heading;
    logic signed [23:0] turn_rate;
  } tail_t;

  logic [15:0] time_step_r;
  logic        en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RESET;
    end else if (cfg_wr_en) begin
      time_step_r <= cfg_wr_data;
    end
  end

  // input unpack and heading increment product
  side_t              in_side;
  logic signed [16:0] dt_s;

  assign dt_s = $signed({1'b0, time_step_r});

  always_comb begin
    in_side.pos_x     = $signed(in_tdata[31:0]);
    in_side.pos_y     = $signed(in_tdata[63:32]);
    in_side.speed     = $signed(in_tdata[95:64]);
    in_side.heading   = in_tdata[111:96];
    in_side.turn_rate = $signed(in_tdata[135:112]);
    in_side.rate_prod = in_side.turn_rate * dt_s;
  end

  logic               c_valid;
  logic signed [31:0] c_cos;
  logic signed [31:0] c_sin;
  side_t              c_side;

  trms_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .heading   (in_tdata[111:96]),
    .in_side   (in_side),
    .out_valid (c_valid),
    .cos_val   (c_cos),
    .sin_val   (c_sin),
    .out_side  (c_side)
  );

  logic signed [31:0] next_x;
  logic signed [31:0] next_y;
  logic               sat_x;
  logic               sat_y;

  trms_scale u_scale_x (
    .clk       (clk),
    .en        (en),
    .trig      (c_cos),
    .speed     (c_side.speed),
    .pos       (c_side.pos_x),
    .time_step (time_step_r),
    .result    (next_x),
    .sat       (sat_x)
  );

  trms_scale u_scale_y (
    .clk       (clk),
    .en        (en),
    .trig      (c_sin),
    .speed     (c_side.speed),
    .pos       (c_side.pos_y),
    .time_step (time_step_r),
    .result    (next_y),
    .sat       (sat_y)
  );

  // pass-through fields and heading update, aligned with the scale stages
  logic               tv_r   [0:SCALE_STAGES-1];
  tail_t              tail_r [0:SCALE_STAGES-1];
  logic signed [40:0] rate_rnd;
  tail_t              tail_nxt;

  assign rate_rnd = c_side.rate_prod + 41'sd32768;

  always_comb begin
    tail_nxt.speed     = c_side.speed;
    tail_nxt.heading   = c_side.heading + rate_rnd[31:16];
    tail_nxt.turn_rate = c_side.turn_rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCALE_STAGES; i++) begin
        tv_r[i] <= 1'b0;
      end
    end else if (en) begin
      tv_r[0] <= c_valid;
      for (int i = 1; i < SCALE_STAGES; i++) begin
        tv_r[i] <= tv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r[0] <= tail_nxt;
      for (int i = 1; i < SCALE_STAGES; i++) begin
        tail_r[i] <= tail_r[i-1];
      end
    end
  end

  assign en         = !tv_r[SCALE_STAGES-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = tv_r[SCALE_STAGES-1];
  assign out_tdata  = {tail_r[SCALE_STAGES-1].turn_rate,
                       tail_r[SCALE_STAGES-1].heading,
                       tail_r[SCALE_STAGES-1].speed,
                       next_y, next_x};
  assign out_tuser  = sat_x | sat_y;

  // saturated results sit on a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[31:0] == 32'h7FFFFFFF) || (out_tdata[31:0] == 32'h80000000) ||
      (out_tdata[63:32] == 32'h7FFFFFFF) || (out_tdata[63:32] == 32'h80000000))
    else $error("saturated flag set without a clamped position");

  // a stall freezes the tail stages
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(tail_r[0]) && $stable(tail_r[SCALE_STAGES-1]) &&
            $stable(tv_r[0]))
    else $error("pipeline moved during a stall");

  // a stall never drops the waiting result
  a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(next_x) && $stable(next_y) && $stable(out_tuser))
    else $error("scale stage moved during a stall");

endmodule
